// ===== hw/rtl/b64d_pkg.sv =====
package b64d_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DIGIT     = 3'd1;
    localparam logic [2:0] ST_PAD       = 3'd2;
    localparam logic [2:0] ST_AFTER_PAD = 3'd3;
    localparam logic [2:0] ST_SPACE     = 3'd4;

    localparam logic [7:0]  PAD_CHAR  = 8'h3D;
    localparam logic [15:0] CAP_RESET = 16'hFFFF;

    // one work unit handed from front to back: up to three bytes, then an
    // optional error beat
    typedef struct packed {
        logic [23:0] group;
        logic [1:0]  nbytes;
        logic [2:0]  status;
        logic        fin;
    } job_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        s.valid = 1'b1;
        s.value = 6'd0;
        if (c >= 8'd65 && c <= 8'd90) begin
            s.value = 6'(c - 8'd65);
        end else if (c >= 8'd97 && c <= 8'd122) begin
            s.value = 6'(c - 8'd97 + 8'd26);
        end else if (c >= 8'd48 && c <= 8'd57) begin
            s.value = 6'(c - 8'd48 + 8'd52);
        end else if (c == 8'd43) begin
            s.value = 6'd62;
        end else if (c == 8'd47) begin
            s.value = 6'd63;
        end else begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

endpackage

// ===== hw/rtl/b64d_front.sv =====
module b64d_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        enc_char,
    input  logic              final_char,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data,
    input  logic              fifo_full,
    output logic              job_push,
    output b64d_pkg::job_t    job
);
    import b64d_pkg::*;

    logic [15:0] cap_reg;
    logic [1:0]  pos_reg, pos_next;
    logic [17:0] acc_reg, acc_next;
    logic [1:0]  pad_reg, pad_next;
    logic [16:0] be_reg, be_next;
    logic        failed_reg, failed_next;

    logic        accept;
    logic        fail;
    logic [2:0]  fail_st;
    logic        do_emit;
    logic        clear_msg;
    logic [23:0] grp;
    logic [1:0]  want;
    logic [1:0]  fit;
    logic [16:0] room;
    sextet_t     sx;

    assign cfg_ready = 1'b1;
    assign full      = fifo_full;
    assign accept    = push && !fifo_full;
    assign sx        = sextet_of(enc_char);

    // bytes still allowed before the capacity is hit
    assign room = {1'b0, cap_reg} - be_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        pad_next    = pad_reg;
        be_next     = be_reg;
        failed_next = failed_reg;
        fail        = 1'b0;
        fail_st     = ST_OK;
        do_emit     = 1'b0;
        clear_msg   = 1'b0;
        grp         = '0;
        want        = 2'd0;
        fit         = 2'd0;
        job_push    = 1'b0;
        job         = '0;

        if (accept)
        begin
            if (failed_reg)
            begin
                clear_msg = final_char;
            end
            else if (pad_reg != 2'd0 && pos_reg == 2'd0)
            begin
                fail    = 1'b1;
                fail_st = ST_AFTER_PAD;
            end
            else if (enc_char == PAD_CHAR)
            begin
                if (pos_reg < 2'd2)
                begin
                    fail    = 1'b1;
                    fail_st = ST_PAD;
                end
                else if (pos_reg == 2'd2)
                begin
                    acc_next = {acc_reg[11:0], 6'd0};
                    pad_next = 2'd1;
                    pos_next = 2'd3;
                    fail     = final_char;
                    fail_st  = ST_PAD;
                end
                else
                begin
                    grp      = {acc_reg, 6'd0};
                    want     = (pad_reg == 2'd1) ? 2'd1 : 2'd2;
                    pad_next = pad_reg + 2'd1;
                    pos_next = 2'd0;
                    acc_next = '0;
                    do_emit  = 1'b1;
                end
            end
            else if (pad_reg != 2'd0)
            begin
                fail    = 1'b1;
                fail_st = ST_AFTER_PAD;
            end
            else if (!sx.valid)
            begin
                fail    = 1'b1;
                fail_st = ST_DIGIT;
            end
            else if (pos_reg != 2'd3)
            begin
                acc_next = {acc_reg[11:0], sx.value};
                pos_next = pos_reg + 2'd1;
                fail     = final_char;
                fail_st  = ST_PAD;
            end
            else
            begin
                grp      = {acc_reg, sx.value};
                want     = 2'd3;
                pos_next = 2'd0;
                acc_next = '0;
                do_emit  = 1'b1;
            end
        end

        if (fail)
        begin
            job_push   = 1'b1;
            job.status = fail_st;
            job.fin    = final_char;
            clear_msg  = final_char;
            if (!final_char)
            begin
                failed_next = 1'b1;
            end
        end

        if (do_emit)
        begin
            if (be_reg >= {1'b0, cap_reg})
            begin
                fit = 2'd0;
            end
            else if (room < {15'd0, want})
            begin
                fit = room[1:0];
            end
            else
            begin
                fit = want;
            end
            job_push   = 1'b1;
            job.group  = grp;
            job.nbytes = fit;
            job.status = (fit != want) ? ST_SPACE : ST_OK;
            job.fin    = final_char;
            be_next    = be_reg + {15'd0, fit};
            clear_msg  = final_char;
            if (!final_char && fit != want)
            begin
                failed_next = 1'b1;
            end
        end

        if (clear_msg)
        begin
            pos_next    = '0;
            acc_next    = '0;
            pad_next    = '0;
            be_next     = '0;
            failed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAP_RESET;
            pos_reg    <= '0;
            acc_reg    <= '0;
            pad_reg    <= '0;
            be_reg     <= '0;
            failed_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
            pad_reg    <= pad_next;
            be_reg     <= be_next;
            failed_reg <= failed_next;
        end
    end

`ifndef SYNTH
    // a job always has something to deliver
    a_job_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (job.nbytes != 2'd0 || job.status != ST_OK))
        else $error("front pushed an empty job");
`endif

endmodule

// ===== hw/rtl/b64d_fifo.sv =====
module b64d_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  b64d_pkg::job_t    wr_data,
    output logic              full,
    input  logic              rd_en,
    output b64d_pkg::job_t    rd_data,
    output logic              empty
);
    import b64d_pkg::*;

    localparam logic [FIFO_AW:0] DEPTH_CNT = (FIFO_AW + 1)'(FIFO_DEPTH);

    job_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("job queue count out of range");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("job queue read while empty");
`endif

endmodule

// ===== hw/rtl/b64d_back.sv =====
module b64d_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  b64d_pkg::job_t    job,
    output logic              job_pop,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        data_byte,
    output logic [2:0]        status,
    output logic              end_of_message
);
    import b64d_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg;
    logic [7:0] data_reg;
    logic [2:0] status_reg;
    logic       eom_reg;

    logic       load;
    logic       is_byte;
    logic       last;
    logic       last_byte;
    logic [7:0] sel_byte;
    logic [7:0] res_data;
    logic [2:0] res_status;
    logic       res_eom;

    // output register refills when empty or being taken this cycle
    assign load      = job_valid && (!out_valid_reg || pop);
    assign is_byte   = idx_reg < job.nbytes;
    assign last_byte = (idx_reg == job.nbytes - 2'd1);

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = job.group[23:16];
            2'd1:    sel_byte = job.group[15:8];
            default: sel_byte = job.group[7:0];
        endcase
    end

    always_comb
    begin
        if (is_byte)
        begin
            res_data   = sel_byte;
            res_status = ST_OK;
            res_eom    = job.fin && job.status == ST_OK && last_byte;
            last       = job.status == ST_OK && last_byte;
        end
        else
        begin
            // trailing error beat
            res_data   = 8'd0;
            res_status = job.status;
            res_eom    = 1'b1;
            last       = 1'b1;
        end
    end

    assign job_pop  = load && last;
    assign idx_next = load ? (last ? 2'd0 : idx_reg + 2'd1) : idx_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg   <= res_data;
            status_reg <= res_status;
            eom_reg    <= res_eom;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty          = !out_valid_reg;
    assign data_byte      = data_reg;
    assign status         = status_reg;
    assign end_of_message = eom_reg;

`ifndef SYNTH
    a_err_beat_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |-> (eom_reg && data_reg == 8'd0))
        else $error("error beat without end flag or with data");
`endif

endmodule

// ===== hw/rtl/base64_stream_decoder.sv =====
// Base64 stream decoder: one character per cycle in unless full is set, one result beat
// per cycle out while pop is held. A result passes through the job queue and then the
// output register on its way to the ports. The result side outruns the at most three
// beats of a quartet. A four-entry job queue absorbs stalls.
// Reset (async, active low) clears message state and sets the capacity to 65535.
module base64_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  enc_char,
    input  logic        final_char,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  data_byte,
    output logic [2:0]  status,
    output logic        end_of_message,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import b64d_pkg::*;

    logic job_push;
    job_t job_in;
    logic fifo_full;
    logic fifo_empty;
    logic job_pop;
    job_t job_head;

    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .enc_char   (enc_char),
        .final_char (final_char),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fifo_full  (fifo_full),
        .job_push   (job_push),
        .job        (job_in)
    );

    b64d_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (fifo_full),
        .rd_en   (job_pop),
        .rd_data (job_head),
        .empty   (fifo_empty)
    );

    b64d_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (!fifo_empty),
        .job            (job_head),
        .job_pop        (job_pop),
        .empty          (empty),
        .pop            (pop),
        .data_byte      (data_byte),
        .status         (status),
        .end_of_message (end_of_message)
    );

endmodule
